// File: rtl/tptt_pkg.sv
`default_nettype none
package tptt_pkg;

  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned CLS_W = 2;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned SPD_W = 24;
  localparam int unsigned SEC_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACC2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'(2 * NUM_CLASSES);
  localparam logic [DIST_W-1:0] TOL_RESET = 32'd512;
  localparam logic [SEC_W-1:0] SEC_SAT = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_AR,
    ST_MUL_TT,
    ST_MUL_UU,
    ST_MUL_DD,
    ST_MUL_AT,
    ST_SELECT,
    ST_SQRT,
    ST_TRI,
    ST_DIV_CHK,
    ST_DIV,
    ST_DONE
  } tptt_state_t;

endpackage
`default_nettype wire

// File: rtl/tptt_if.sv
`default_nettype none
interface tptt_in_if;
  logic valid;
  logic ready;
  logic [tptt_pkg::CLS_W-1:0] class_index;
  logic [tptt_pkg::DIST_W-1:0] distance;
  logic [tptt_pkg::SPD_W-1:0] current_speed;
  logic last_leg;
  modport source(output valid, class_index, distance, current_speed, last_leg, input ready);
  modport sink(input valid, class_index, distance, current_speed, last_leg, output ready);
endinterface

interface tptt_out_if;
  logic valid;
  logic ready;
  logic [tptt_pkg::SEC_W-1:0] leg_seconds;
  logic leg_unable;
  logic [tptt_pkg::SEC_W-1:0] group_seconds;
  logic group_none;
  logic group_done;
  modport source(output valid, leg_seconds, leg_unable, group_seconds, group_none, group_done,
                 input ready);
  modport sink(input valid, leg_seconds, leg_unable, group_seconds, group_none, group_done,
               output ready);
endinterface

interface tptt_cfg_if;
  logic valid;
  logic ready;
  logic [tptt_pkg::CFG_IDX_W-1:0] index;
  logic [tptt_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/trapezoid_profile_travel_time_top.sv
`default_nettype none
// Trapezoid profile travel time.
// in_chan takes one leg word (class, distance Q24.8, speed Q16.8, last flag).
// out_chan returns one result word per leg: leg time in seconds Q24.8
// (saturating), an unable flag, and on the last leg of a group the slowest
// reachable leg time of that group.
// cfg_chan writes registers: 0 arrival tolerance, then top speed and accel
// for each class in turn. It is always ready; write only while idle.
// Sequence: a leg within tolerance or of a class that cannot move goes from
// the start state straight to done. A computed leg on the trapezoid path
// takes five products on one shared 24x32 multiplier, a select state, a
// range check and 32 division steps; the triangle path runs a 32-step
// square root before the range check and division. A saturating time skips
// the division steps.
// Flow: one leg is worked at a time; in_chan is ready only while the
// sequencer is idle, so a new leg is taken only after the last one is done.
// The result sits in an output register, so the next leg is accepted
// while the receiver stalls; a finished leg then waits until that register
// frees up.
// Reset (rst_n low, synchronous) sets the tolerance to 2.0 m, clears all
// class settings and the group state, and empties the output register.
module trapezoid_profile_travel_time_top (
  input wire clk,
  input wire rst_n,
  tptt_in_if.sink in_chan,
  tptt_out_if.source out_chan,
  tptt_cfg_if.sink cfg_chan
);

  // configuration
  logic [tptt_pkg::DIST_W-1:0] tol_r;
  logic [tptt_pkg::SPD_W-1:0] top_r [tptt_pkg::NUM_CLASSES];
  logic [tptt_pkg::SPD_W-1:0] acc_r [tptt_pkg::NUM_CLASSES];

  // sequencer
  tptt_pkg::tptt_state_t state_r, state_nxt;
  logic [4:0] cnt_r;

  // leg captured at accept
  logic [tptt_pkg::CLS_W-1:0] cls_r;
  logic [tptt_pkg::DIST_W-1:0] dist_r;
  logic [tptt_pkg::SPD_W-1:0] spd_r;
  logic last_r;

  // working values
  logic [tptt_pkg::SPD_W-1:0] t_r, a_r, u_r;
  logic [tptt_pkg::DIST_W-1:0] r_r;
  logic [55:0] ar_r;
  logic [47:0] tt_r, uu_r, dd_r, at_r;
  logic [65:0] num_r;
  logic [47:0] den_r;
  logic [63:0] rem_r, root_r, sbit_r;
  logic [31:0] quo_r;
  logic [tptt_pkg::SEC_W-1:0] secs_r;
  logic unable_r;

  // group state
  logic [tptt_pkg::SEC_W-1:0] slow_r;
  logic any_r;

  // output register
  logic out_valid_r;
  logic [tptt_pkg::SEC_W-1:0] o_leg_r, o_grp_r;
  logic o_unable_r, o_none_r, o_done_r;

  // shared multiplier and control
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [55:0] prod;
  logic accept, load;
  logic trap_sel;
  logic [57:0] ar2;
  logic [64:0] sq_try;
  logic [31:0] num_lo;
  logic [48:0] div_sh;
  logic div_ge;
  logic div_sat;
  logic [23:0] t_sel, a_sel;
  logic cls_ok;
  logic [25:0] u4;
  logic [tptt_pkg::SEC_W-1:0] new_slow;
  logic new_any;
  logic [2:0] cfg_k;
  logic [1:0] cfg_cls;

  assign prod = mul_a * mul_b;
  assign ar2 = {1'b0, ar_r, 1'b0};
  assign trap_sel = {ar_r, 1'b0} >= ({1'b0, tt_r, 1'b0} - {9'd0, uu_r});
  assign sq_try = {1'b0, root_r} + {1'b0, sbit_r};
  assign num_lo = num_r[31:0];
  assign div_sh = {rem_r[47:0], num_lo[cnt_r]};
  assign div_ge = div_sh >= {1'b0, den_r};
  // quotient of 33 bits or more when the upper numerator reaches the divisor
  assign div_sat = {14'd0, num_r[65:32]} >= den_r;
  assign u4 = {u_r, 2'b00};
  assign cls_ok = 32'(cls_r) < tptt_pkg::NUM_CLASSES;
  assign t_sel = cls_ok ? top_r[cls_r] : '0;
  assign a_sel = cls_ok ? acc_r[cls_r] : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tptt_pkg::ST_IDLE: if (in_chan.valid) state_nxt = tptt_pkg::ST_START;
      tptt_pkg::ST_START: begin
        if (dist_r <= tol_r || t_sel == '0 || a_sel == '0) state_nxt = tptt_pkg::ST_DONE;
        else state_nxt = tptt_pkg::ST_MUL_AR;
      end
      tptt_pkg::ST_MUL_AR: state_nxt = tptt_pkg::ST_MUL_TT;
      tptt_pkg::ST_MUL_TT: state_nxt = tptt_pkg::ST_MUL_UU;
      tptt_pkg::ST_MUL_UU: state_nxt = tptt_pkg::ST_MUL_DD;
      tptt_pkg::ST_MUL_DD: state_nxt = tptt_pkg::ST_MUL_AT;
      tptt_pkg::ST_MUL_AT: state_nxt = tptt_pkg::ST_SELECT;
      tptt_pkg::ST_SELECT: state_nxt = trap_sel ? tptt_pkg::ST_DIV_CHK : tptt_pkg::ST_SQRT;
      tptt_pkg::ST_SQRT: if (cnt_r == '0) state_nxt = tptt_pkg::ST_TRI;
      tptt_pkg::ST_TRI: begin
        if (root_r < {38'd0, u4}) state_nxt = tptt_pkg::ST_DONE;
        else state_nxt = tptt_pkg::ST_DIV_CHK;
      end
      tptt_pkg::ST_DIV_CHK: begin
        if (div_sat) state_nxt = tptt_pkg::ST_DONE;
        else state_nxt = tptt_pkg::ST_DIV;
      end
      tptt_pkg::ST_DIV: if (cnt_r == '0) state_nxt = tptt_pkg::ST_DONE;
      tptt_pkg::ST_DONE: if (!out_valid_r || out_chan.ready) state_nxt = tptt_pkg::ST_IDLE;
      default: state_nxt = tptt_pkg::ST_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    in_chan.ready = 1'b0;
    load = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tptt_pkg::ST_IDLE: in_chan.ready = 1'b1;
      tptt_pkg::ST_MUL_AR: begin
        mul_a = a_r;
        mul_b = r_r;
      end
      tptt_pkg::ST_MUL_TT: begin
        mul_a = t_r;
        mul_b = {8'd0, t_r};
      end
      tptt_pkg::ST_MUL_UU: begin
        mul_a = u_r;
        mul_b = {8'd0, u_r};
      end
      tptt_pkg::ST_MUL_DD: begin
        mul_a = t_r - u_r;
        mul_b = {8'd0, t_r - u_r};
      end
      tptt_pkg::ST_MUL_AT: begin
        mul_a = a_r;
        mul_b = {8'd0, t_r};
      end
      tptt_pkg::ST_DONE: load = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  // capture leg and run datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= in_chan.class_index;
      dist_r <= in_chan.distance;
      spd_r <= in_chan.current_speed;
      last_r <= in_chan.last_leg;
    end
    case (state_r)
      tptt_pkg::ST_START: begin
        secs_r <= '0;
        unable_r <= (dist_r > tol_r) && (t_sel == '0 || a_sel == '0);
        t_r <= t_sel;
        a_r <= a_sel;
        u_r <= (spd_r > t_sel) ? t_sel : spd_r;
        r_r <= dist_r - tol_r;
      end
      tptt_pkg::ST_MUL_AR: ar_r <= prod;
      tptt_pkg::ST_MUL_TT: tt_r <= prod[47:0];
      tptt_pkg::ST_MUL_UU: uu_r <= prod[47:0];
      tptt_pkg::ST_MUL_DD: dd_r <= prod[47:0];
      tptt_pkg::ST_MUL_AT: at_r <= prod[47:0];
      tptt_pkg::ST_SELECT: begin
        // trapezoid: 128*((T-U)^2 + T^2 + 2AR) / (A*T)
        num_r <= {1'b0, 58'(ar2 + {10'd0, dd_r} + {10'd0, tt_r}), 7'd0};
        den_r <= at_r;
        // triangle: root of 32*(2AR + U^2)
        rem_r <= {1'b0, 58'(ar2 + {10'd0, uu_r}), 5'd0};
        root_r <= '0;
        sbit_r <= 64'd1 << 62;
        cnt_r <= 5'd31;
      end
      tptt_pkg::ST_SQRT: begin
        if ({1'b0, rem_r} >= sq_try) begin
          rem_r <= rem_r - sq_try[63:0];
          root_r <= (root_r >> 1) + sbit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
      end
      tptt_pkg::ST_TRI: begin
        num_r <= {28'd0, 32'(root_r[31:0] - {6'd0, u4}), 6'd0};
        den_r <= {24'd0, a_r};
      end
      tptt_pkg::ST_DIV_CHK: begin
        // quotient of 33 bits or more saturates
        if (div_sat) secs_r <= tptt_pkg::SEC_SAT;
        rem_r <= {30'd0, num_r[65:32]};
        cnt_r <= 5'd31;
      end
      tptt_pkg::ST_DIV: begin
        if (div_ge) rem_r <= {15'd0, div_sh - {1'b0, den_r}};
        else rem_r <= {15'd0, div_sh};
        quo_r <= {quo_r[30:0], div_ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) secs_r <= {quo_r[30:0], div_ge};
      end
      default: ;
    endcase
  end

  // group tracking: keep the slowest reachable leg
  always_comb begin
    new_any = any_r || !unable_r;
    new_slow = slow_r;
    if (!unable_r && (!any_r || secs_r > slow_r)) new_slow = secs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tptt_pkg::ST_IDLE;
      slow_r <= '0;
      any_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
        slow_r <= last_r ? '0 : new_slow;
        any_r <= last_r ? 1'b0 : new_any;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      o_leg_r <= secs_r;
      o_unable_r <= unable_r;
      o_grp_r <= (last_r && new_any) ? new_slow : '0;
      o_none_r <= last_r && !new_any;
      o_done_r <= last_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.leg_seconds = o_leg_r;
  assign out_chan.leg_unable = o_unable_r;
  assign out_chan.group_seconds = o_grp_r;
  assign out_chan.group_none = o_none_r;
  assign out_chan.group_done = o_done_r;

  // configuration writes: index 1.. alternates top speed and accel per class
  assign cfg_chan.ready = 1'b1;
  assign cfg_k = cfg_chan.index - tptt_pkg::REG_TOP0;
  assign cfg_cls = cfg_k[2:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= tptt_pkg::TOL_RESET;
      for (int i = 0; i < tptt_pkg::NUM_CLASSES; i++) begin
        top_r[i] <= '0;
        acc_r[i] <= '0;
      end
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == tptt_pkg::REG_TOL) begin
        tol_r <= cfg_chan.data;
      end else if (cfg_chan.index <= tptt_pkg::REG_LAST) begin
        if (!cfg_k[0]) top_r[cfg_cls] <= cfg_chan.data[23:0];
        else acc_r[cfg_cls] <= cfg_chan.data[23:0];
      end
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tptt_pkg::ST_IDLE) |-> !in_chan.ready)
    else $error("input taken while a leg is in work");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tptt_pkg::ST_DIV) |-> (rem_r[48:0] < {1'b0, den_r}))
    else $error("division remainder out of range");

  a_unable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_unable_r && o_leg_r != '0))
    else $error("unable leg with nonzero time");

  a_group_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_done_r) |-> (o_grp_r == '0 && !o_none_r))
    else $error("group fields set on a non-final leg");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(o_leg_r)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// File: dv/tptt_travel_checker.sv
module tptt_travel_checker (
  input wire clk,
  input wire rst_n,
  tptt_in_if.sink in_mon,
  tptt_out_if.sink out_mon,
  tptt_cfg_if.sink cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned groups_seen
);

  typedef struct packed {
    logic [tptt_pkg::SEC_W-1:0] leg_seconds;
    logic leg_unable;
    logic [tptt_pkg::SEC_W-1:0] group_seconds;
    logic group_none;
    logic group_done;
  } leg_result_t;

  logic [31:0] tol_q;
  logic [23:0] vmax_q [tptt_pkg::NUM_CLASSES];
  logic [23:0] acc_q [tptt_pkg::NUM_CLASSES];
  logic [31:0] slowest_q;
  logic reach_q;
  leg_result_t expected_results [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, bit_v;
    rem = x;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] profile_seconds(input logic [63:0] r, u, t, a);
    logic [63:0] twoar, n, d, q, rm, v, s;
    twoar = 2 * a * r;
    if (twoar >= 2 * t * t - u * u) begin
      n = (t - u) * (t - u) + t * t + twoar;
      d = a * t;
      q = n / d;
      rm = n % d;
      if (q >= (64'd1 << 25)) return tptt_pkg::SEC_SAT;
      v = q * 128 + (rm * 128) / d;
      return (v > 64'hFFFF_FFFF) ? tptt_pkg::SEC_SAT : v[31:0];
    end
    s = int_sqrt(32 * (twoar + u * u));
    if (s < 4 * u) return 0;
    v = (64 * (s - 4 * u)) / a;
    return (v > 64'hFFFF_FFFF) ? tptt_pkg::SEC_SAT : v[31:0];
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    leg_result_t e, got;
    logic [63:0] t, a, u;
    logic [31:0] secs;
    logic unable;
    logic [2:0] cfg_off;
    logic [1:0] cfg_slot;
    if (!rst_n) begin
      tol_q <= tptt_pkg::TOL_RESET;
      for (int i = 0; i < tptt_pkg::NUM_CLASSES; i++) begin
        vmax_q[i] <= 0;
        acc_q[i] <= 0;
      end
      slowest_q <= 0;
      reach_q <= 0;
      fail_count <= 0;
      groups_seen <= 0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        cfg_off = cfg_mon.index - tptt_pkg::REG_TOP0;
        cfg_slot = cfg_off[2:1];
        if (cfg_mon.index == tptt_pkg::REG_TOL) tol_q <= cfg_mon.data;
        else if (cfg_mon.index <= tptt_pkg::REG_LAST) begin
          if (cfg_mon.index[0]) vmax_q[cfg_slot] <= cfg_mon.data[23:0];
          else acc_q[cfg_slot] <= cfg_mon.data[23:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        secs = 0;
        unable = 0;
        if (in_mon.distance > tol_q) begin
          t = 0;
          a = 0;
          if (in_mon.class_index < tptt_pkg::NUM_CLASSES) begin
            t = vmax_q[in_mon.class_index];
            a = acc_q[in_mon.class_index];
          end
          if (t == 0 || a == 0) unable = 1;
          else begin
            u = (in_mon.current_speed > t) ? t : in_mon.current_speed;
            secs = profile_seconds(in_mon.distance - tol_q, u, t, a);
          end
        end
        e.leg_seconds = secs;
        e.leg_unable = unable;
        e.group_seconds = 0;
        e.group_none = 0;
        e.group_done = 0;
        if (in_mon.last_leg) begin
          e.group_done = 1;
          if (!unable) e.group_seconds = (!reach_q || secs > slowest_q) ? secs : slowest_q;
          else if (reach_q) e.group_seconds = slowest_q;
          e.group_none = !(reach_q || !unable);
          slowest_q <= 0;
          reach_q <= 0;
        end else if (!unable) begin
          if (!reach_q || secs > slowest_q) slowest_q <= secs;
          reach_q <= 1;
        end
        expected_results.push_back(e);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.leg_seconds, out_mon.leg_unable, out_mon.group_seconds,
                out_mon.group_none, out_mon.group_done};
        if (got.group_done) groups_seen <= groups_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (got != e) begin
            $display("%0t: mismatch expected secs=%h unable=%b grp=%h none=%b done=%b",
                     $time, e.leg_seconds, e.leg_unable, e.group_seconds, e.group_none,
                     e.group_done);
            $display("%0t:          actual   secs=%h unable=%b grp=%h none=%b done=%b",
                     $time, got.leg_seconds, got.leg_unable, got.group_seconds,
                     got.group_none, got.group_done);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb.sv
module tb;

  logic clk = 0;
  logic rst_n = 0;
  int unsigned fail_count, pending_count, groups_seen;
  int unsigned cycle_count = 0;
  int unsigned legs_sent = 0;
  int unsigned phases_run = 0;

  tptt_in_if in_chan ();
  tptt_out_if out_chan ();
  tptt_cfg_if cfg_chan ();

  trapezoid_profile_travel_time_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  tptt_travel_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan), .cfg_mon(cfg_chan),
    .fail_count(fail_count), .pending_count(pending_count), .groups_seen(groups_seen)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Watchdog: end the run with an error once the cycle counter passes its limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("[trapezoid_profile_travel_time_top] ERROR");
      $finish;
    end
  end

  // Receiver: hold ready low for a random stretch before each word.
  initial begin
    int unsigned gap;
    out_chan.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_chan.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1;
      @(posedge clk iff out_chan.valid);
    end
  end

  task automatic write_reg(input logic [tptt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    cfg_chan.valid <= 1;
    @(posedge clk iff cfg_chan.ready);
    cfg_chan.valid <= 0;
    @(posedge clk);
  endtask

  // Send one leg word after a random gap; keep valid high across back-to-back words.
  task automatic send_leg(input logic [1:0] cls, input logic [31:0] leg_dist,
                          input logic [23:0] spd, input logic last, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_chan.class_index <= cls;
    in_chan.distance <= leg_dist;
    in_chan.current_speed <= spd;
    in_chan.last_leg <= last;
    in_chan.valid <= 1;
    @(posedge clk iff in_chan.ready);
    legs_sent++;
  endtask

  // Drain: drop valid, wait for every result, then let the sequencer settle.
  task automatic drain();
    in_chan.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_speed(input int unsigned mode);
    case (mode)
      0: return 24'h000001;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 255));
      default: return 24'($urandom_range(1, 24'h00FFFF));
    endcase
  endfunction

  initial begin
    logic [31:0] leg_dist;
    bit burst;
    in_chan.valid = 0;
    in_chan.class_index = 0;
    in_chan.distance = 0;
    in_chan.current_speed = 0;
    in_chan.last_leg = 0;
    cfg_chan.valid = 0;
    cfg_chan.index = 0;
    cfg_chan.data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings: every class is unable, tolerance 2.0 m.
    send_leg(2'd0, 32'd512, 24'd100, 1'b0, 1'b0);
    send_leg(2'd1, 32'd513, 24'd100, 1'b0, 1'b0);
    send_leg(2'd3, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
    send_leg(2'd2, 32'd1000, 24'd0, 1'b1, 1'b0);
    drain();

    // Directed: extremes of class settings and fields.
    write_reg(tptt_pkg::REG_TOL, 32'd0);
    write_reg(tptt_pkg::REG_TOP0, 32'h00FFFFFF);
    write_reg(tptt_pkg::REG_ACC0, 32'h00FFFFFF);
    write_reg(tptt_pkg::REG_TOP1, 32'd1);
    write_reg(tptt_pkg::REG_ACC1, 32'd1);
    write_reg(tptt_pkg::REG_TOP2, 32'd2560);
    write_reg(tptt_pkg::REG_ACC2, 32'd0);
    send_leg(2'd0, 32'hFFFFFFFF, 24'd0, 1'b0, 1'b0);
    send_leg(2'd0, 32'd1, 24'hFFFFFF, 1'b0, 1'b0);
    send_leg(2'd1, 32'hFFFFFFFF, 24'd0, 1'b0, 1'b0);
    send_leg(2'd1, 32'd1, 24'd0, 1'b0, 1'b0);
    send_leg(2'd1, 32'd300, 24'd5, 1'b0, 1'b0);
    send_leg(2'd2, 32'd500, 24'd10, 1'b1, 1'b0);
    send_leg(2'd3, 32'd0, 24'd0, 1'b1, 1'b0);
    send_leg(2'd3, 32'd5, 24'd0, 1'b1, 1'b0);
    send_leg(2'd0, 32'd0, 24'd0, 1'b1, 1'b0);
    drain();
    write_reg(tptt_pkg::REG_TOL, 32'hFFFFFFFF);
    send_leg(2'd1, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
    drain();

    // Random phases with mostly realistic settings, a few extreme ones.
    for (int ph = 0; ph < 12; ph++) begin
      phases_run++;
      write_reg(tptt_pkg::REG_TOL, (ph % 5 == 4) ? $urandom : $urandom_range(0, 4096));
      for (int k = 1; k <= tptt_pkg::REG_LAST; k++) begin
        if ($urandom_range(0, 9) == 0) write_reg(3'(k), 32'd0);
        else if ($urandom_range(0, 9) == 0) write_reg(3'(k), 32'h00FFFFFF);
        else write_reg(3'(k), $urandom_range(1, (k % 2) ? 24'h00FFFF : 24'h000FFF));
      end
      for (int n = 0; n < 112; n++) begin
        burst = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 5))
          0: leg_dist = $urandom;
          1: leg_dist = $urandom_range(0, 8192);
          default: leg_dist = $urandom_range(0, 32'h00FFFFFF);
        endcase
        send_leg(($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)), leg_dist,
                 ($urandom_range(0, 5) == 0) ? 24'd0 : rand_speed($urandom_range(0, 6)),
                 ($urandom_range(0, 3) == 0), burst);
        if (ph == 5 && n == 50) begin
          // Hold off the sender until the pipeline is empty.
          in_chan.valid <= 0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
      drain();
    end
    send_leg(2'd0, 32'd0, 24'd0, 1'b1, 1'b0);
    drain();

    $display("Sent %0d legs over %0d random phases; %0d group results checked.",
             legs_sent, phases_run, groups_seen);
    if (fail_count == 0) begin
      $display("[trapezoid_profile_travel_time_top] OK");
    end else begin
      $display("[trapezoid_profile_travel_time_top] ERROR");
    end
    $finish;
  end
endmodule
